FILE: design/calu_pkg.sv
package calu_pkg;

  localparam int unsigned CmdW  = 5;
  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 16;
  localparam int unsigned FlagW = 4;

  // Bit positions within the flag nibble.
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  typedef enum logic [CmdW-1:0] {
    CmdAdd       = 5'd0,
    CmdAdc       = 5'd1,
    CmdSub       = 5'd2,
    CmdSbc       = 5'd3,
    CmdAnd       = 5'd4,
    CmdOr        = 5'd5,
    CmdXor       = 5'd6,
    CmdCp        = 5'd7,
    CmdInc       = 5'd8,
    CmdDec       = 5'd9,
    CmdSwap      = 5'd10,
    CmdRlc       = 5'd11,
    CmdRl        = 5'd12,
    CmdRrc       = 5'd13,
    CmdRr        = 5'd14,
    CmdSla       = 5'd15,
    CmdSra       = 5'd16,
    CmdSrl       = 5'd17,
    CmdAddHl     = 5'd18,
    CmdLoadA     = 5'd19,
    CmdLoadHl    = 5'd20,
    CmdLoadFlags = 5'd21
  } calu_cmd_e;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [WordW-1:0] operand;
  } calu_in_t;

  typedef struct packed {
    logic [ByteW-1:0] result;
    logic [WordW-1:0] hl_value;
    logic [FlagW-1:0] flags_out;
  } calu_out_t;

  typedef struct packed {
    logic [ByteW-1:0] acc;
    logic [WordW-1:0] hl;
    logic [FlagW-1:0] flags;
  } calu_state_t;

endpackage

FILE: design/calu_exec.sv
module calu_exec import calu_pkg::*; (
  input  calu_in_t         item_i,
  input  calu_state_t      state_i,
  output calu_state_t      state_o,
  output logic [ByteW-1:0] result_o
);

  calu_cmd_e        cmd;
  logic [ByteW-1:0] a;
  logic [ByteW-1:0] n;
  logic [WordW-1:0] op;
  logic             cin;
  logic             cy_add;
  logic             cy_sub;
  logic [ByteW:0]   sum9;
  logic [4:0]       half_add;
  logic [ByteW:0]   diff9;
  logic [4:0]       half_sub;
  logic [WordW:0]   sum17;
  logic [12:0]      half13;
  logic [ByteW-1:0] r;
  calu_state_t      nxt;

  assign cmd = calu_cmd_e'(item_i.command);
  assign op  = item_i.operand;
  assign n   = op[ByteW-1:0];
  assign a   = state_i.acc;
  assign cin = state_i.flags[FlagC];

  assign cy_add = cin & (cmd == CmdAdc);
  assign cy_sub = cin & (cmd == CmdSbc);

  // The carry goes into the wide sum, so an operand of all ones still carries out.
  assign sum9     = {1'b0, a} + {1'b0, n} + {{ByteW{1'b0}}, cy_add};
  assign half_add = {1'b0, a[3:0]} + {1'b0, n[3:0]} + {4'b0, cy_add};
  // The top bit of each difference is the borrow out of that width.
  assign diff9    = {1'b0, a} - {1'b0, n} - {{ByteW{1'b0}}, cy_sub};
  assign half_sub = {1'b0, a[3:0]} - {1'b0, n[3:0]} - {4'b0, cy_sub};
  assign sum17    = {1'b0, state_i.hl} + {1'b0, op};
  assign half13   = {1'b0, state_i.hl[11:0]} + {1'b0, op[11:0]};

  always_comb begin
    r   = a;
    nxt = state_i;
    case (cmd)
      CmdAdd, CmdAdc: begin
        r         = sum9[ByteW-1:0];
        nxt.acc   = r;
        nxt.flags = {r == '0, 1'b0, half_add[4], sum9[ByteW]};
      end
      CmdSub, CmdSbc, CmdCp: begin
        r         = diff9[ByteW-1:0];
        nxt.flags = {r == '0, 1'b1, half_sub[4], diff9[ByteW]};
        if (cmd != CmdCp) begin
          nxt.acc = r;
        end
      end
      CmdAnd: begin
        r         = a & n;
        nxt.acc   = r;
        nxt.flags = {r == '0, 1'b0, 1'b1, 1'b0};
      end
      CmdOr, CmdXor: begin
        r         = (cmd == CmdOr) ? (a | n) : (a ^ n);
        nxt.acc   = r;
        nxt.flags = {r == '0, 1'b0, 1'b0, 1'b0};
      end
      CmdInc: begin
        r         = n + 8'd1;
        nxt.flags = {r == '0, 1'b0, n[3:0] == 4'hF, cin};
      end
      CmdDec: begin
        r         = n - 8'd1;
        nxt.flags = {r == '0, 1'b1, n[3:0] == 4'h0, cin};
      end
      CmdSwap: begin
        r         = {n[3:0], n[7:4]};
        nxt.flags = {r == '0, 1'b0, 1'b0, 1'b0};
      end
      CmdRlc, CmdRl, CmdSla: begin
        case (cmd)
          CmdRlc:  r = {n[6:0], n[7]};
          CmdRl:   r = {n[6:0], cin};
          default: r = {n[6:0], 1'b0};
        endcase
        nxt.flags = {r == '0, 1'b0, 1'b0, n[7]};
      end
      CmdRrc, CmdRr, CmdSra, CmdSrl: begin
        case (cmd)
          CmdRrc:  r = {n[0], n[7:1]};
          CmdRr:   r = {cin, n[7:1]};
          CmdSra:  r = {n[7], n[7:1]};
          default: r = {1'b0, n[7:1]};
        endcase
        nxt.flags = {r == '0, 1'b0, 1'b0, n[0]};
      end
      CmdAddHl: begin
        nxt.hl    = sum17[WordW-1:0];
        nxt.flags = {state_i.flags[FlagZ], 1'b0, half13[12], sum17[WordW]};
      end
      CmdLoadA: begin
        r       = n;
        nxt.acc = n;
      end
      CmdLoadHl: begin
        nxt.hl = op;
      end
      CmdLoadFlags: begin
        nxt.flags = op[FlagW-1:0];
      end
      default: begin
        r   = a;
        nxt = state_i;
      end
    endcase
  end

  assign state_o  = nxt;
  assign result_o = r;

endmodule

FILE: design/cpu_alu_with_flags.sv
// Throughput: one item per cycle while the output is not stalled; the execute
// step from the input register to the result register also updates A, HL and
// the flags, so each item sees the state left by the one before it.
// Reset (rst_ni low, asynchronous) clears A, HL, the flags and both valid bits.
module cpu_alu_with_flags import calu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  calu_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output calu_out_t out_data_o
);

  calu_in_t         in_q;
  logic             in_valid_q;
  calu_state_t      state_q;
  calu_state_t      state_d;
  logic [ByteW-1:0] result_d;
  calu_out_t        out_q;
  logic             out_valid_q;
  logic             advance;

  // The held item executes once the result register is free or being drained.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  calu_exec u_exec (
    .item_i   (in_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q.result    <= result_d;
      out_q.hl_value  <= state_d.hl;
      out_q.flags_out <= state_d.flags;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: design/calu_chk.sv
module calu_chk import calu_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input calu_out_t out_data_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before its transfer");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // The input side only stalls when a result is waiting on a blocked output.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // A fresh result follows an earlier input transfer.
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result appeared without a matching input transfer");

endmodule

bind cpu_alu_with_flags calu_chk u_calu_chk (.*);
